@@ rtl/core/sdpg_pkg.sv @@
// Shared types and constants for the stereo distance pan gain core.
// Used by every module of the core; depends on nothing.
`default_nettype none

package sdpg_pkg;

   // Fixed-point scale: Q1.16 fractions, 65536 is 1.0.
   localparam logic [16:0] Q_ONE = 17'h10000;

   // Angles in 1/64 degree.
   localparam logic [14:0] DEG180_U = 15'd11520;
   localparam logic signed [15:0] DEG90 = 16'sd5760;
   localparam logic signed [15:0] DEG180 = 16'sd11520;
   localparam logic signed [15:0] DEG360 = 16'sd23040;

   // Reciprocal of 45/512 in Q20, floor(2^29/45), for the pan scaling.
   localparam logic [23:0] PAN_RECIP = 24'd11930464;
   localparam logic [5:0] PAN_DIV = 6'd45;

   // Reciprocal of 255 in Q24, floor(2^24/255), for the mixer scaling.
   localparam logic [16:0] VOL_RECIP = 17'd65793;
   localparam logic [7:0] VOL_DIV = 8'd255;
   localparam logic [16:0] VOL_SAT = 17'd32640;
   localparam logic [7:0] MIX_MAX = 8'd128;

   localparam logic [6:0] PAN_SCALE = 7'd127;
   localparam logic [7:0] PAN_SPAN = 8'd254;

   // Quotient bits produced by each divider pipeline.
   localparam int QBITS = 16;

   // Reset values of the configuration registers.
   localparam logic [19:0] ATTEN_START_RST = 20'd4096;
   localparam logic [19:0] ATTEN_END_RST = 20'd32400;
   localparam logic [7:0] MASTER_VOLUME_RST = 8'd255;

   typedef enum logic [1:0] {
      CSR_ATTEN_START   = 2'd0,
      CSR_ATTEN_END     = 2'd1,
      CSR_MASTER_VOLUME = 2'd2
   } csr_index_type;

   // How the distance gain is formed.
   typedef enum logic [1:0] {
      GAIN_FULL = 2'd0,
      GAIN_ZERO = 2'd1,
      GAIN_DIV  = 2'd2
   } gain_mode_type;

   typedef struct packed {
      logic        absolute_mode;
      logic        spatial_enabled;
      logic        attenuate;
      logic        tracking;
      logic [19:0] distance;
      logic [14:0] angle;
      logic [16:0] channel_volume;
   } req_type;

   typedef struct packed {
      logic [7:0] mix_level;
      logic [7:0] left_level;
      logic [7:0] right_level;
      logic       pan_valid;
   } rsp_type;

   // Per-request side information carried along the pipeline.
   typedef struct packed {
      logic          absolute;
      gain_mode_type gmode;
      logic          ip_full;
      logic          damp;
      logic          pan_neg;
      logic [16:0]   pan_mag;
      logic [16:0]   cv;
   } ctx_type;

   typedef struct packed {
      logic [19:0] num;
      logic [19:0] den;
      ctx_type     ctx;
   } div_in_type;

   typedef struct packed {
      logic [15:0] quo;
      ctx_type     ctx;
   } div_out_type;

endpackage

`default_nettype wire

@@ rtl/core/sdpg_front.sv @@
// Front stages: range classification, angle folding and pan magnitude.
// Depends on sdpg_pkg.
`default_nettype none

module sdpg_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [19:0]         atten_start,
   input  wire logic [19:0]         atten_end,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire sdpg_pkg::req_type   in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output sdpg_pkg::div_in_type     out_data
);

   logic [2:0] v_ff;
   logic [3:0] en;

   // Each stage moves when it is empty or the next one moves.
   assign en[3] = out_ready;
   assign en[2] = ~v_ff[2] | en[3];
   assign en[1] = ~v_ff[1] | en[2];
   assign en[0] = ~v_ff[0] | en[1];
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   // Stage one: gain classification and angle folding.
   logic [19:0] size, diff;
   logic below, above;
   logic signed [15:0] ang, s, w, src, src_abs;
   logic front, pan_en;
   sdpg_pkg::gain_mode_type gmode;
   sdpg_pkg::ctx_type s1_ctx_in;
   logic [12:0] s1_x_in;

   always_comb begin
      below = in_data.distance < atten_start;
      above = in_data.distance > atten_end;
      size  = atten_end - atten_start;
      diff  = in_data.distance - atten_start;
      if (in_data.absolute_mode || !in_data.spatial_enabled || !in_data.attenuate || below)
         gmode = sdpg_pkg::GAIN_FULL;
      else if (above)
         gmode = sdpg_pkg::GAIN_ZERO;
      else if (size == 20'd0)
         gmode = sdpg_pkg::GAIN_FULL;
      else
         gmode = sdpg_pkg::GAIN_DIV;

      ang = $signed({1'b0, in_data.angle});
      s = (in_data.angle > sdpg_pkg::DEG180_U) ? ang - sdpg_pkg::DEG360 : ang;
      front = (s <= sdpg_pkg::DEG90) && (s >= -sdpg_pkg::DEG90);
      w = (s > 16'sd0) ? s - sdpg_pkg::DEG180 : s + sdpg_pkg::DEG180;
      src = front ? s : w;
      src_abs = (src < 16'sd0) ? -src : src;
      pan_en = !in_data.absolute_mode && in_data.spatial_enabled && in_data.tracking;

      s1_ctx_in.absolute = in_data.absolute_mode;
      s1_ctx_in.gmode    = gmode;
      s1_ctx_in.ip_full  = (diff == size);
      s1_ctx_in.damp     = pan_en && !front;
      s1_ctx_in.pan_neg  = pan_en && (front ? (s > 16'sd0) : (w < 16'sd0));
      s1_ctx_in.pan_mag  = '0;
      s1_ctx_in.cv       = in_data.channel_volume;
      s1_x_in = pan_en ? src_abs[12:0] : 13'd0;
   end

   sdpg_pkg::ctx_type s1_ctx_ff, s2_ctx_ff;
   logic [19:0] s1_num_ff, s1_den_ff, s2_num_ff, s2_den_ff;
   logic [12:0] s1_x_ff, s2_x_ff;
   logic [16:0] s2_q_ff;

   // Stage two: reciprocal multiply for the pan magnitude.
   logic [36:0] pan_prod;
   assign pan_prod = {24'd0, s1_x_ff} * {13'd0, sdpg_pkg::PAN_RECIP};

   // Stage three: one correction step makes the quotient exact.
   logic [22:0] q45;
   logic [21:0] pan_rem;
   logic [16:0] pan_mag;
   sdpg_pkg::ctx_type s3_ctx;
   always_comb begin
      q45 = {6'd0, s2_q_ff} * {17'd0, sdpg_pkg::PAN_DIV};
      pan_rem = {s2_x_ff, 9'd0} - q45[21:0];
      pan_mag = (pan_rem >= {16'd0, sdpg_pkg::PAN_DIV}) ? s2_q_ff + 17'd1 : s2_q_ff;
      s3_ctx = s2_ctx_ff;
      s3_ctx.pan_mag = pan_mag;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ctx_ff <= s1_ctx_in;
         s1_num_ff <= diff;
         s1_den_ff <= size;
         s1_x_ff   <= s1_x_in;
      end
      if (en[1]) begin
         s2_ctx_ff <= s1_ctx_ff;
         s2_num_ff <= s1_num_ff;
         s2_den_ff <= s1_den_ff;
         s2_x_ff   <= s1_x_ff;
         s2_q_ff   <= pan_prod[36:20];
      end
      if (en[2]) begin
         out_data.num <= s2_num_ff;
         out_data.den <= s2_den_ff;
         out_data.ctx <= s3_ctx;
      end
   end

   assign out_valid = v_ff[2];

endmodule

`default_nettype wire

@@ rtl/core/sdpg_div.sv @@
// Pipelined fractional divider: one quotient bit per stage, num below den.
// Depends on sdpg_pkg.
`default_nettype none

module sdpg_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire sdpg_pkg::div_in_type   in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output sdpg_pkg::div_out_type       out_data
);

   localparam int N = sdpg_pkg::QBITS;

   logic [N-1:0]  v_ff;
   logic [N:0]    en;
   logic [19:0]   rem_ff [N];
   logic [19:0]   den_ff [N];
   logic [N-1:0]  quo_ff [N];
   sdpg_pkg::ctx_type ctx_ff [N];

   assign en[N] = out_ready;
   assign in_ready = en[0];

   for (genvar gi = 0; gi < N; gi++) begin : g_stage
      logic [19:0] r_src, d_src;
      logic [N-1:0] q_src;
      sdpg_pkg::ctx_type c_src;
      logic v_src;
      logic [20:0] t, t_sub;
      logic ge;

      if (gi == 0) begin : g_first
         assign r_src = in_data.num;
         assign d_src = in_data.den;
         assign q_src = '0;
         assign c_src = in_data.ctx;
         assign v_src = in_valid;
      end else begin : g_next
         assign r_src = rem_ff[gi-1];
         assign d_src = den_ff[gi-1];
         assign q_src = quo_ff[gi-1];
         assign c_src = ctx_ff[gi-1];
         assign v_src = v_ff[gi-1];
      end

      // A stage moves when it is empty or the next one moves.
      assign en[gi] = ~v_ff[gi] | en[gi+1];

      // Shift the remainder and subtract the divisor where it fits.
      assign t = {r_src, 1'b0};
      assign ge = t >= {1'b0, d_src};
      assign t_sub = t - {1'b0, d_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[gi] <= 1'b0;
         end else if (en[gi]) begin
            v_ff[gi] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[gi]) begin
            rem_ff[gi] <= ge ? t_sub[19:0] : t[19:0];
            den_ff[gi] <= d_src;
            quo_ff[gi] <= {q_src[N-2:0], ge};
            ctx_ff[gi] <= c_src;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_data.quo = quo_ff[N-1];
   assign out_data.ctx = ctx_ff[N-1];

endmodule

`default_nettype wire

@@ rtl/core/sdpg_mid.sv @@
// Turns the distance fraction into the roll-off numerator and divisor.
// Depends on sdpg_pkg.
`default_nettype none

module sdpg_mid (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire sdpg_pkg::div_out_type  in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output sdpg_pkg::div_in_type        out_data
);

   logic v_ff;
   logic [16:0] ip;
   sdpg_pkg::ctx_type ctx;

   assign in_ready = ~v_ff | out_ready;

   // The fraction is exactly 1.0 when the distance sits at the range end.
   always_comb begin
      ip = in_data.ctx.ip_full ? sdpg_pkg::Q_ONE : {1'b0, in_data.quo};
      ctx = in_data.ctx;
      if (in_data.ctx.gmode == sdpg_pkg::GAIN_DIV && ip == 17'd0)
         ctx.gmode = sdpg_pkg::GAIN_FULL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   // Gain is (1 - x) / (1 + 8x): numerator stays below divisor unless x is 0.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_data.num <= {3'd0, sdpg_pkg::Q_ONE - ip};
         out_data.den <= {3'd0, sdpg_pkg::Q_ONE} + {ip, 3'd0};
         out_data.ctx <= ctx;
      end
   end

   assign out_valid = v_ff;

endmodule

`default_nettype wire

@@ rtl/core/sdpg_back.sv @@
// Back stages: gain selection, rear damping, volume scaling and pan levels.
// Depends on sdpg_pkg.
`default_nettype none

module sdpg_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             master_volume,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire sdpg_pkg::div_out_type  in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output sdpg_pkg::rsp_type           out_data
);

   logic [5:0] v_ff;
   logic [6:0] en;

   assign en[6] = out_ready;
   for (genvar gi = 0; gi < 6; gi++) begin : g_en
      assign en[gi] = ~v_ff[gi] | en[gi+1];
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
         if (en[4]) v_ff[4] <= v_ff[3];
         if (en[5]) v_ff[5] <= v_ff[4];
      end
   end

   sdpg_pkg::ctx_type c1_ff, c2_ff, c3_ff, c4_ff;
   logic [16:0] g1_ff, g2_ff;
   logic [33:0] p3_ff;
   logic [41:0] p4_ff;
   logic        abs5_ff, sat5_ff;
   logic [14:0] t5_ff;
   logic [7:0]  q5_ff, right5_ff;

   // Stage one: pick the gain.
   logic [16:0] g_sel;
   always_comb begin
      case (in_data.ctx.gmode)
         sdpg_pkg::GAIN_FULL: g_sel = sdpg_pkg::Q_ONE;
         sdpg_pkg::GAIN_DIV:  g_sel = {1'b0, in_data.quo};
         default:             g_sel = 17'd0;
      endcase
   end

   // Stage two: sounds from behind are damped by (1 + |pan|) / 2.
   logic [34:0] damp_prod;
   assign damp_prod = {18'd0, g1_ff} * ({18'd0, sdpg_pkg::Q_ONE} + {18'd0, c1_ff.pan_mag});

   // Stage five: scale to the mixer range and form the pan levels.
   logic [16:0] t;
   logic [31:0] vq_prod;
   logic [17:0] pan_off;
   logic [24:0] pan_prod;
   always_comb begin
      t = p4_ff[41:25];
      vq_prod = {17'd0, t[14:0]} * {15'd0, sdpg_pkg::VOL_RECIP};
      pan_off = c4_ff.pan_neg ? {1'b0, sdpg_pkg::Q_ONE} - {1'b0, c4_ff.pan_mag}
                              : {1'b0, sdpg_pkg::Q_ONE} + {1'b0, c4_ff.pan_mag};
      pan_prod = {7'd0, pan_off} * {18'd0, sdpg_pkg::PAN_SCALE};
   end

   // Stage six: one correction step for the division by 255.
   logic [15:0] q255;
   logic [14:0] vol_rem;
   logic [7:0]  vol;
   always_comb begin
      q255 = {8'd0, q5_ff} * {8'd0, sdpg_pkg::VOL_DIV};
      vol_rem = t5_ff - q255[14:0];
      if (sat5_ff)
         vol = sdpg_pkg::MIX_MAX;
      else if (vol_rem >= {7'd0, sdpg_pkg::VOL_DIV})
         vol = q5_ff + 8'd1;
      else
         vol = q5_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c1_ff <= in_data.ctx;
         g1_ff <= g_sel;
      end
      if (en[1]) begin
         c2_ff <= c1_ff;
         g2_ff <= c1_ff.damp ? damp_prod[33:17] : g1_ff;
      end
      if (en[2]) begin
         c3_ff <= c2_ff;
         p3_ff <= {17'd0, c2_ff.cv} * {17'd0, g2_ff};
      end
      if (en[3]) begin
         c4_ff <= c3_ff;
         p4_ff <= {8'd0, p3_ff} * {34'd0, master_volume};
      end
      if (en[4]) begin
         abs5_ff   <= c4_ff.absolute;
         sat5_ff   <= t >= sdpg_pkg::VOL_SAT;
         t5_ff     <= t[14:0];
         q5_ff     <= vq_prod[31:24];
         right5_ff <= pan_prod[23:16];
      end
      if (en[5]) begin
         out_data.mix_level   <= vol;
         out_data.right_level <= abs5_ff ? 8'd0 : right5_ff;
         out_data.left_level  <= abs5_ff ? 8'd0 : sdpg_pkg::PAN_SPAN - right5_ff;
         out_data.pan_valid   <= ~abs5_ff;
      end
   end

   assign out_valid = v_ff[5];

endmodule

`default_nettype wire

@@ rtl/core/stereo_distance_pan_gain_core.sv @@
// Top level of the stereo distance pan gain core: configuration registers
// and the pipeline chain. Depends on sdpg_pkg and all sdpg_ modules.
//
// The core takes one request per clock cycle unless the response side stalls,
// and returns one response per request, in order, through its pipeline of
// 3 front stages, two 16-stage divider pipelines that give one quotient bit
// per stage, 1 stage between them and 6 back stages. Each stage holds its
// own valid bit and moves whenever it is empty or the next stage moves, so
// empty slots fill while a response waits. The configuration registers may
// be written only while no request is in flight.
`default_nettype none

module stereo_distance_pan_gain_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire sdpg_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output sdpg_pkg::rsp_type       rsp_data,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [19:0]        csr_wdata
);

   logic [19:0] atten_start_ff, atten_end_ff;
   logic [7:0]  master_volume_ff;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         atten_start_ff   <= sdpg_pkg::ATTEN_START_RST;
         atten_end_ff     <= sdpg_pkg::ATTEN_END_RST;
         master_volume_ff <= sdpg_pkg::MASTER_VOLUME_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            sdpg_pkg::CSR_ATTEN_START:   atten_start_ff   <= csr_wdata;
            sdpg_pkg::CSR_ATTEN_END:     atten_end_ff     <= csr_wdata;
            sdpg_pkg::CSR_MASTER_VOLUME: master_volume_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic front_valid, front_ready, div1_valid, div1_ready;
   logic mid_valid, mid_ready, div2_valid, div2_ready;
   sdpg_pkg::div_in_type  front_data, mid_data;
   sdpg_pkg::div_out_type div1_data, div2_data;

   // Range classification and pan magnitude.
   sdpg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .atten_start (atten_start_ff),
      .atten_end   (atten_end_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_data     (req_data),
      .out_valid   (front_valid),
      .out_ready   (front_ready),
      .out_data    (front_data)
   );

   // Position within the attenuation range.
   sdpg_div u_div_frac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div1_valid),
      .out_ready (div1_ready),
      .out_data  (div1_data)
   );

   sdpg_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div1_valid),
      .in_ready  (div1_ready),
      .in_data   (div1_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   // Roll-off gain.
   sdpg_div u_div_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (div2_valid),
      .out_ready (div2_ready),
      .out_data  (div2_data)
   );

   sdpg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .master_volume (master_volume_ff),
      .in_valid      (div2_valid),
      .in_ready      (div2_ready),
      .in_data       (div2_data),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_data      (rsp_data)
   );

endmodule

`default_nettype wire
